/* design/stdti_pkg.sv */
// Shared widths, item types and codes for the speed-to-duty table interpolator.
package stdti_pkg;

    localparam int TABLE_ENTRIES_DEF = 385;
    localparam int SCALE_SHIFT_DEF   = 2;

    localparam int KIND_W        = 1;
    localparam int ENTRY_INDEX_W = 9;
    localparam int SPEED_W       = 16;
    localparam int DUTY_W        = 11;

    // Numerator width of the interpolation division at the default sizes
    localparam int DIV_NUM_W_DEF = SPEED_W + $clog2(TABLE_ENTRIES_DEF) + SCALE_SHIFT_DEF;

    localparam logic [KIND_W-1:0] KIND_WRITE = 1'b0;
    localparam logic [KIND_W-1:0] KIND_QUERY = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [ENTRY_INDEX_W-1:0] entry_index;
        logic [SPEED_W-1:0]       entry_speed;
        logic [SPEED_W-1:0]       query_speed;
    } cmd_item_t;

    typedef struct packed {
        logic [DUTY_W-1:0]        duty;
        logic [ENTRY_INDEX_W-1:0] nearest_index;
    } res_item_t;

endpackage

/* design/stdti_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module stdti_div #(
    parameter int NUM_W = stdti_pkg::DIV_NUM_W_DEF,
    parameter int DEN_W = stdti_pkg::SPEED_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);
    import stdti_pkg::*;

    localparam int CW = $clog2(NUM_W + 1);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    // Bring down the next numerator bit and try a subtract
    always_comb
    begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});
    end

    // Load on start, then shift one bit per cycle
    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CW'(NUM_W);
            rem_next = '0;
            quo_next = num;
            den_next = den;
        end
        else if (run_reg)
        begin
            rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !run_reg)
        else $error("divider started while still running");

endmodule

/* design/speed_to_duty_table_interpolator.sv */
// Top level: calibration table memory, nearest-entry search and interpolation.
//
// After reset the block sweeps zeros through the table, one entry per cycle, and keeps
// busy high until all TABLE_ENTRIES entries (385 by default) are cleared. A write item
// is taken while idle and gives no result. A query scans the whole table through its
// single read port, then steps over flat entries toward the query, then for an
// interpolated answer sets up the operands, runs the bit-serial divider and finishes.
// Each result appears on result for one cycle with done high and must be captured then.
module speed_to_duty_table_interpolator #(
    parameter int TABLE_ENTRIES = stdti_pkg::TABLE_ENTRIES_DEF,
    parameter int SCALE_SHIFT   = stdti_pkg::SCALE_SHIFT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  stdti_pkg::cmd_item_t  command,
    output logic                  done,
    output stdti_pkg::res_item_t  result
);
    import stdti_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = AW + 1;
    localparam int PW = AW + SCALE_SHIFT;
    localparam int NW = SPEED_W + AW + SCALE_SHIFT;
    localparam int SW = NW + 1;
    localparam int XW = AW + ENTRY_INDEX_W;
    localparam int MW = SPEED_W + AW;

    localparam logic [CW-1:0] N_C     = CW'(TABLE_ENTRIES);
    localparam logic [AW-1:0] LAST_C  = AW'(TABLE_ENTRIES - 1);
    localparam logic [XW-1:0] N_X     = XW'(TABLE_ENTRIES);
    localparam logic [PW-1:0] MAX_PWM = PW'((TABLE_ENTRIES - 1) << SCALE_SHIFT);

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_SCAN  = 7'b0000100,
        ST_WALK  = 7'b0001000,
        ST_MUL   = 7'b0010000,
        ST_DIVGO = 7'b0100000,
        ST_DIV   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Table memory
    logic [SPEED_W-1:0] mem [TABLE_ENTRIES];
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [SPEED_W-1:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [SPEED_W-1:0] rd_data_reg;

    // Control
    logic [AW-1:0]      clr_reg, clr_next;
    logic [CW-1:0]      scan_reg, scan_next;
    logic               scan_vld_reg, scan_vld_next;
    logic               have_cal_reg, have_cal_next;
    logic               walk_vld_reg, walk_vld_next;
    logic               done_reg, done_next;
    logic               div_start;
    logic               div_done;

    // Datapath
    logic [SPEED_W-1:0] q_reg, q_next;
    logic [AW-1:0]      scan_idx_reg, scan_idx_next;
    logic [SPEED_W-1:0] min_reg, min_next;
    logic [AW-1:0]      best_idx_reg, best_idx_next;
    logic [SPEED_W-1:0] best_spd_reg, best_spd_next;
    logic [SPEED_W-1:0] best_err_reg, best_err_next;
    logic               dir_up_reg, dir_up_next;
    logic [CW-1:0]      probe_reg, probe_next;
    logic               walk_oob_reg, walk_oob_next;
    logic [AW-1:0]      walk_idx_reg, walk_idx_next;
    logic [AW-1:0]      other_reg, other_next;
    logic [SPEED_W-1:0] v_other_reg, v_other_next;
    logic [NW-1:0]      num_reg, num_next;
    logic [SPEED_W-1:0] den_reg, den_next;
    logic               den_neg_reg, den_neg_next;
    res_item_t          result_reg, result_next;

    logic               accept;
    logic [XW-1:0]      idx_x;
    logic               scan_issue;
    logic [SPEED_W-1:0] err;
    logic               dead;
    logic [PW-1:0]      base_pwm;
    logic [SPEED_W-1:0] dq;
    logic [AW-1:0]      di;
    logic [MW-1:0]      prod;
    logic [NW-1:0]      quo;
    logic [SW-1:0]      sum_up;
    logic [PW-1:0]      pwm_fin;
    logic [PW-1:0]      res_pwm;
    logic [AW-1:0]      res_idx;
    logic [PW+DUTY_W-1:0]        duty_wide;
    logic [AW+ENTRY_INDEX_W-1:0] idx_wide;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign idx_x  = XW'(command.entry_index);

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[mem_raddr];
    end

    // Per-entry scan arithmetic and interpolation terms
    always_comb
    begin
        err      = (q_reg > rd_data_reg) ? (q_reg - rd_data_reg) : (rd_data_reg - q_reg);
        dead     = !have_cal_reg || (q_reg <= min_reg) || (best_idx_reg == '0);
        base_pwm = PW'(best_idx_reg) << SCALE_SHIFT;
        dq       = dir_up_reg ? (q_reg - best_spd_reg) : (best_spd_reg - q_reg);
        di       = dir_up_reg ? (other_reg - best_idx_reg) : (best_idx_reg - other_reg);
        prod     = MW'(dq) * MW'(di);
        sum_up   = SW'(base_pwm) + SW'(quo);
        if (den_neg_reg)
        begin
            pwm_fin = (quo > NW'(base_pwm)) ? '0 : (base_pwm - quo[PW-1:0]);
        end
        else
        begin
            pwm_fin = (sum_up > SW'(MAX_PWM)) ? MAX_PWM : sum_up[PW-1:0];
        end
    end

    // Sequence clear, scan, walk and divide
    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        scan_next     = scan_reg;
        scan_vld_next = 1'b0;
        have_cal_next = have_cal_reg;
        walk_vld_next = walk_vld_reg;
        done_next     = 1'b0;
        q_next        = q_reg;
        scan_idx_next = scan_idx_reg;
        min_next      = min_reg;
        best_idx_next = best_idx_reg;
        best_spd_next = best_spd_reg;
        best_err_next = best_err_reg;
        dir_up_next   = dir_up_reg;
        probe_next    = probe_reg;
        walk_oob_next = walk_oob_reg;
        walk_idx_next = walk_idx_reg;
        other_next    = other_reg;
        v_other_next  = v_other_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        den_neg_next  = den_neg_reg;
        mem_we        = 1'b0;
        mem_waddr     = clr_reg;
        mem_wdata     = '0;
        mem_raddr     = scan_reg[AW-1:0];
        div_start     = 1'b0;
        scan_issue    = 1'b0;
        res_pwm       = '0;
        res_idx       = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST_C)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (command.kind == KIND_WRITE)
                    begin
                        mem_we    = (idx_x < N_X);
                        mem_waddr = idx_x[AW-1:0];
                        mem_wdata = command.entry_speed;
                    end
                    else
                    begin
                        q_next        = command.query_speed;
                        scan_next     = '0;
                        have_cal_next = 1'b0;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // Issue one read per cycle, judge the entry read last cycle
                scan_issue    = (scan_reg < N_C);
                scan_vld_next = scan_issue;
                scan_idx_next = scan_reg[AW-1:0];
                if (scan_issue)
                begin
                    scan_next = scan_reg + CW'(1);
                end
                if (scan_vld_reg && (rd_data_reg != '0))
                begin
                    if (!have_cal_reg)
                    begin
                        have_cal_next = 1'b1;
                        min_next      = rd_data_reg;
                        best_idx_next = scan_idx_reg;
                        best_spd_next = rd_data_reg;
                        best_err_next = err;
                    end
                    else if (err < best_err_reg)
                    begin
                        best_idx_next = scan_idx_reg;
                        best_spd_next = rd_data_reg;
                        best_err_next = err;
                    end
                end
                if (!scan_issue && !scan_vld_reg)
                begin
                    priority if (dead)
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (best_spd_reg == q_reg)
                    begin
                        done_next  = 1'b1;
                        res_pwm    = base_pwm;
                        res_idx    = best_idx_reg;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        dir_up_next   = (q_reg > best_spd_reg);
                        probe_next    = (q_reg > best_spd_reg) ?
                                        (CW'(best_idx_reg) + CW'(1)) :
                                        (CW'(best_idx_reg) - CW'(1));
                        walk_vld_next = 1'b0;
                        state_next    = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                // Step over flat entries toward the query, one probe per cycle
                mem_raddr     = probe_reg[AW-1:0];
                probe_next    = dir_up_reg ? (probe_reg + CW'(1)) : (probe_reg - CW'(1));
                walk_vld_next = 1'b1;
                walk_oob_next = (probe_reg >= N_C);
                walk_idx_next = probe_reg[AW-1:0];
                if (walk_vld_reg)
                begin
                    priority if (walk_oob_reg || (rd_data_reg == '0))
                    begin
                        done_next  = 1'b1;
                        res_pwm    = base_pwm;
                        res_idx    = best_idx_reg;
                        state_next = ST_IDLE;
                    end
                    else if (rd_data_reg != best_spd_reg)
                    begin
                        other_next   = walk_idx_reg;
                        v_other_next = rd_data_reg;
                        state_next   = ST_MUL;
                    end
                    else
                    begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_MUL:
            begin
                num_next     = NW'(prod) << SCALE_SHIFT;
                den_neg_next = (v_other_reg < best_spd_reg);
                den_next     = (v_other_reg < best_spd_reg) ?
                               (best_spd_reg - v_other_reg) : (v_other_reg - best_spd_reg);
                state_next   = ST_DIVGO;
            end
            ST_DIVGO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    done_next  = 1'b1;
                    res_pwm    = pwm_fin;
                    res_idx    = best_idx_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Truncate result fields to the port widths
    always_comb
    begin
        duty_wide                 = (PW + DUTY_W)'(res_pwm);
        idx_wide                  = (AW + ENTRY_INDEX_W)'(res_idx);
        result_next.duty          = duty_wide[DUTY_W-1:0];
        result_next.nearest_index = idx_wide[ENTRY_INDEX_W-1:0];
    end

    stdti_div #(
        .NUM_W (NW),
        .DEN_W (SPEED_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (num_reg),
        .den      (den_reg),
        .done     (div_done),
        .quotient (quo)
    );

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            scan_reg     <= '0;
            scan_vld_reg <= 1'b0;
            have_cal_reg <= 1'b0;
            walk_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            scan_reg     <= scan_next;
            scan_vld_reg <= scan_vld_next;
            have_cal_reg <= have_cal_next;
            walk_vld_reg <= walk_vld_next;
            done_reg     <= done_next;
        end
    end

    // Hold datapath
    always_ff @(posedge clk)
    begin
        q_reg        <= q_next;
        scan_idx_reg <= scan_idx_next;
        min_reg      <= min_next;
        best_idx_reg <= best_idx_next;
        best_spd_reg <= best_spd_next;
        best_err_reg <= best_err_next;
        dir_up_reg   <= dir_up_next;
        probe_reg    <= probe_next;
        walk_oob_reg <= walk_oob_next;
        walk_idx_reg <= walk_idx_next;
        other_reg    <= other_next;
        v_other_reg  <= v_other_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        den_neg_reg  <= den_neg_next;
        result_reg   <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a query in progress");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two result strobes in a row");

    a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (command.kind == KIND_WRITE)) |=> (!busy && !done))
        else $error("write item caused work or a result");

    a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide step");

endmodule

/* dv/tb_speed_to_duty_table_interpolator.sv */
// Testbench for the speed-to-duty table interpolator: directed and random items, scored on the fly.
`timescale 1ns / 100ps

module tb_speed_to_duty_table_interpolator;

    import stdti_pkg::*;

    localparam int N_ENTRIES    = TABLE_ENTRIES_DEF;
    localparam int DUTY_SHIFT   = SCALE_SHIFT_DEF;
    localparam int RANDOM_ITEMS = 400;
    localparam int TAIL_CYCLES  = 600;
    localparam int CYCLE_LIMIT  = 2_000_000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        done;
    cmd_item_t   command;
    res_item_t   result;

    // Predictor state: a copy of the calibration table
    logic [SPEED_W-1:0] cal_speed [N_ENTRIES];
    res_item_t          pending_duty_q [$];

    bit burst_mode;
    int error_count;
    int n_writes;
    int n_ignored;
    int n_queries;
    int n_results;

    speed_to_duty_table_interpolator i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .command (command),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Work out the duty and anchor index for one query speed
    function automatic res_item_t lookup_duty(input logic [SPEED_W-1:0] q);
        int        best_idx;
        int        best_err;
        int        min_spd;
        int        err;
        int        s;
        bit        have_cal;
        longint    anchor;
        longint    v_near;
        longint    base;
        longint    dir;
        longint    other;
        longint    den;
        longint    num;
        longint    pwm;
        longint    max_pwm;
        res_item_t r;
        r        = '0;
        best_idx = 0;
        best_err = 32'h7fff_ffff;
        min_spd  = 0;
        have_cal = 1'b0;
        // Find the nearest calibrated entry, lower index on a tie
        for (int i = 0; i < N_ENTRIES; i++)
        begin
            s = int'(cal_speed[i]);
            if (s != 0)
            begin
                if (!have_cal)
                begin
                    min_spd  = s;
                    have_cal = 1'b1;
                end
                err = (int'(q) > s) ? int'(q) - s : s - int'(q);
                if (err < best_err)
                begin
                    best_err = err;
                    best_idx = i;
                end
            end
        end
        // Drop to motor off on empty table, dead zone or anchor at index zero
        if (!have_cal || int'(q) <= min_spd || best_idx == 0)
            return r;
        anchor = best_idx;
        v_near = cal_speed[best_idx];
        base   = anchor << DUTY_SHIFT;
        r.nearest_index = ENTRY_INDEX_W'(anchor);
        r.duty          = DUTY_W'(base);
        if (v_near == longint'(q))
            return r;
        // Step over flat entries toward the query
        dir   = (longint'(q) > v_near) ? 1 : -1;
        other = anchor + dir;
        while (other >= 0 && other <= N_ENTRIES - 1 && longint'(cal_speed[other]) == v_near)
            other += dir;
        if (other < 0 || other > N_ENTRIES - 1)
            return r;
        if (cal_speed[other] == '0)
            return r;
        den = longint'(cal_speed[other]) - v_near;
        if (den == 0)
            return r;
        // Interpolate, truncate toward zero, clamp to the duty range
        num     = (longint'(q) - v_near) * (other - anchor) * (longint'(1) << DUTY_SHIFT);
        pwm     = base + num / den;
        max_pwm = longint'(N_ENTRIES - 1) << DUTY_SHIFT;
        if (pwm < 0)
            pwm = 0;
        if (pwm > max_pwm)
            pwm = max_pwm;
        r.duty = DUTY_W'(pwm);
        return r;
    endfunction

    // Drive one item, wait for the block to take it, then update the predictor
    task automatic send_item(input cmd_item_t item);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        command <= item;
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
        if (item.kind == KIND_WRITE)
        begin
            n_writes++;
            if (item.entry_index < N_ENTRIES)
                cal_speed[item.entry_index] = item.entry_speed;
            else
                n_ignored++;
        end
        else
        begin
            n_queries++;
            pending_duty_q.push_back(lookup_duty(item.query_speed));
        end
    endtask

    task automatic write_entry(input int idx, input int spd);
        cmd_item_t item;
        item.kind        = KIND_WRITE;
        item.entry_index = ENTRY_INDEX_W'(idx);
        item.entry_speed = SPEED_W'(spd);
        item.query_speed = SPEED_W'($urandom_range(0, 65535));
        send_item(item);
    endtask

    task automatic query_speed(input int spd);
        cmd_item_t item;
        item.kind        = KIND_QUERY;
        item.entry_index = ENTRY_INDEX_W'($urandom_range(0, 511));
        item.entry_speed = SPEED_W'($urandom_range(0, 65535));
        item.query_speed = SPEED_W'(spd);
        send_item(item);
    endtask

    // Pick a query near the calibrated part of the table most of the time
    function automatic int pick_query_speed();
        int j;
        int k;
        int n;
        int first;
        int v;
        j     = -1;
        first = -1;
        k     = $urandom_range(0, N_ENTRIES - 1);
        for (n = 0; n < N_ENTRIES; n++)
        begin
            if (cal_speed[(k + n) % N_ENTRIES] != '0)
            begin
                j = (k + n) % N_ENTRIES;
                break;
            end
        end
        for (n = 0; n < N_ENTRIES; n++)
        begin
            if (cal_speed[n] != '0)
            begin
                first = n;
                break;
            end
        end
        if (j < 0)
            return $urandom_range(0, 65535);
        case ($urandom_range(0, 9))
            0, 1, 2:    v = int'(cal_speed[j]);
            3, 4, 5, 6: v = int'(cal_speed[j]) + int'($urandom_range(0, 800)) - 400;
            7:          v = $urandom_range(0, 65535);
            8:          v = int'(cal_speed[first]) + int'($urandom_range(0, 2)) - 1;
            default:    v = ($urandom_range(0, 1) != 0) ? 65535 : 0;
        endcase
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v;
    endfunction

    // Empty table and writes past the end of the table
    task automatic test_empty_table();
        query_speed(0);
        write_entry(511, 65535);
        write_entry(N_ENTRIES, 1234);
        query_speed(65535);
    endtask

    // Anchor at index zero, then the dead zone below the first calibrated entry
    task automatic test_dead_zone();
        write_entry(0, 500);
        query_speed(600);
        write_entry(0, 0);
        write_entry(1, 1000);
        write_entry(2, 2000);
        write_entry(3, 2000);
        write_entry(4, 2000);
        write_entry(5, 3000);
        query_speed(1000);
        query_speed(999);
    endtask

    // Exact hits, flat runs, ties, truncation and missing neighbors
    task automatic test_interpolation();
        query_speed(2000);
        query_speed(1400);
        query_speed(2300);
        query_speed(2900);
        query_speed(2500);
        write_entry(N_ENTRIES - 1, 60000);
        query_speed(65535);
        query_speed(59000);
        write_entry(N_ENTRIES - 1, 65535);
        query_speed(65535);
        write_entry(7, 5000);
        write_entry(8, 4999);
        query_speed(5002);
    endtask

    // Random ramps of calibration data, some noise writes, then queries around them
    task automatic test_random_calibration();
        int goal;
        int b;
        int len;
        int s;
        int i;
        goal = n_writes - n_ignored + n_queries + RANDOM_ITEMS;
        while (n_writes - n_ignored + n_queries < goal)
        begin
            burst_mode = ($urandom_range(0, 3) == 0);
            b   = $urandom_range(0, N_ENTRIES - 1);
            len = $urandom_range(2, 40);
            s   = $urandom_range(1, 30000);
            for (i = 0; i < len && b + i < N_ENTRIES; i++)
            begin
                case ($urandom_range(0, 19))
                    0:       write_entry(b + i, 0);
                    1, 2:
                    begin
                        s = s - int'($urandom_range(0, 500));
                        if (s < 1)
                            s = 1;
                        write_entry(b + i, s);
                    end
                    3, 4, 5: write_entry(b + i, s);
                    default:
                    begin
                        s = s + int'($urandom_range(1, 1500));
                        if (s > 65535)
                            s = 65535;
                        write_entry(b + i, s);
                    end
                endcase
            end
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    write_entry($urandom_range(0, 511), $urandom_range(0, 65535));
            end
            repeat ($urandom_range(3, 12))
                query_speed(pick_query_speed());
        end
        burst_mode = 1'b0;
    endtask

    // Score each result against the oldest prediction
    always @(negedge clk)
    begin
        res_item_t want;
        if (rst_n && done)
        begin
            if (pending_duty_q.size() == 0)
            begin
                $display("%0t: unexpected result: duty %0d, nearest_index %0d",
                         $time, result.duty, result.nearest_index);
                error_count++;
            end
            else
            begin
                want = pending_duty_q.pop_front();
                n_results++;
                if (result.duty !== want.duty)
                begin
                    $display("%0t: duty mismatch: expected %0d, actual %0d",
                             $time, want.duty, result.duty);
                    error_count++;
                end
                if (result.nearest_index !== want.nearest_index)
                begin
                    $display("%0t: nearest_index mismatch: expected %0d, actual %0d",
                             $time, want.nearest_index, result.nearest_index);
                    error_count++;
                end
            end
        end
    end

    // Abort a hung run
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Timeout after %0d cycles, %0d results outstanding",
                 CYCLE_LIMIT, pending_duty_q.size());
        $display("tb_speed_to_duty_table_interpolator failed");
        $finish;
    end

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        command     = '0;
        burst_mode  = 1'b0;
        error_count = 0;
        n_writes    = 0;
        n_ignored   = 0;
        n_queries   = 0;
        n_results   = 0;
        for (int i = 0; i < N_ENTRIES; i++)
            cal_speed[i] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_dead_zone();
        test_interpolation();
        test_random_calibration();

        // Drain outstanding results, then watch for strays
        start <= 1'b0;
        while (pending_duty_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d table writes (%0d out of range) and %0d speed queries,",
                 n_writes, n_ignored, n_queries);
        $display("checked %0d duty results, %0d mismatches", n_results, error_count);
        if (error_count == 0)
            $display("tb_speed_to_duty_table_interpolator passed");
        else
            $display("tb_speed_to_duty_table_interpolator failed");
        $finish;
    end

endmodule
